// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

	localparam logic [9:0] HALF_BIT_RESET = 10'd10;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START    = 5'd1,
		PH_ADDR_W   = 5'd2,
		PH_REG      = 5'd3,
		PH_DATA     = 5'd4,
		PH_STOP_MID = 5'd5,
		PH_GAP      = 5'd6,
		PH_START_R  = 5'd7,
		PH_ADDR_R   = 5'd8,
		PH_READ     = 5'd9,
		PH_STOP_END = 5'd10,
		PH_DONE     = 5'd11
	} phase_t;

	// one tick of the bus timebase
	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic [8:0] read_count;
		logic       sda_sample;
	} tick_item_t;

	// line drive and status for one tick
	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       done;
		logic       ack_missing;
	} tick_res_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_cnt;
		logic [9:0] tick_cnt;
		logic [8:0] bytes_left;
		logic [7:0] shreg;
		logic       nack;
		logic       scl_high;
		logic [1:0] held_op;
		logic [6:0] held_addr;
		logic [7:0] held_reg;
		logic [7:0] held_data;
	} seq_state_t;

endpackage

// ===== rtl/i2cm_core.sv =====
module i2cm_core import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  tick_item_t item,
	input  logic [9:0] half_bit,
	output tick_res_t  res
);

	seq_state_t st_q;
	seq_state_t nx;
	logic       active;
	logic       last_tick;
	logic       reading;
	logic [9:0] len;
	logic [10:0] tick_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	// one tick of the transaction sequencer
	always_comb begin
		nx        = st_q;
		res       = '0;
		res.busy  = 1'b1;
		active    = 1'b1;
		reading   = 1'b0;
		len       = (half_bit == 10'd0) ? 10'd1 : half_bit;
		tick_sum  = '0;
		last_tick = 1'b0;

		if (st_q.phase == PH_IDLE) begin
			if (item.operation == OP_WRITE || item.operation == OP_READ) begin
				nx.held_op    = item.operation;
				nx.held_addr  = item.device_address;
				nx.held_reg   = item.register_address;
				nx.held_data  = item.write_data;
				nx.bytes_left = item.read_count;
				nx.nack       = 1'b0;
				nx.phase      = PH_START;
				nx.tick_cnt   = '0;
				nx.scl_high   = 1'b0;
				nx.bit_cnt    = '0;
			end else begin
				active   = 1'b0;
				res.busy = 1'b0;
			end
		end

		if (active) begin
			tick_sum  = {1'b0, nx.tick_cnt} + 11'd1;
			last_tick = tick_sum >= {1'b0, len};
			case (nx.phase)
				PH_START, PH_START_R: begin
					res.sda_drive_low = 1'b1;
					if (last_tick) begin
						nx.bit_cnt  = '0;
						nx.scl_high = 1'b0;
						if (nx.phase == PH_START) begin
							nx.phase = PH_ADDR_W;
							nx.shreg = {nx.held_addr, 1'b0};
						end else begin
							nx.phase = PH_ADDR_R;
							nx.shreg = {nx.held_addr, 1'b1};
						end
					end
				end
				PH_STOP_MID, PH_STOP_END: begin
					res.scl_drive_low = ~nx.scl_high;
					res.sda_drive_low = 1'b1;
					if (last_tick) begin
						if (!nx.scl_high) begin
							nx.scl_high = 1'b1;
						end else begin
							nx.phase    = (nx.phase == PH_STOP_MID) ? PH_GAP : PH_DONE;
							nx.bit_cnt  = '0;
							nx.scl_high = 1'b0;
							nx.shreg    = '0;
						end
					end
				end
				PH_GAP: begin
					if (last_tick) begin
						nx.phase    = PH_START_R;
						nx.bit_cnt  = '0;
						nx.scl_high = 1'b0;
						nx.shreg    = '0;
					end
				end
				PH_DONE: begin
					res.busy        = 1'b0;
					res.done        = 1'b1;
					res.ack_missing = nx.nack;
					nx.phase        = PH_IDLE;
					last_tick       = 1'b1;
				end
				PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R, PH_READ: begin
					reading           = nx.phase == PH_READ;
					res.scl_drive_low = ~nx.scl_high;
					if (nx.bit_cnt < 4'd8) begin
						res.sda_drive_low = reading ? 1'b0 : ~nx.shreg[7];
					end else begin
						// master ACKs every read byte but the last
						res.sda_drive_low = reading ? (nx.bytes_left != 9'd1) : 1'b0;
					end
					if (last_tick) begin
						if (!nx.scl_high) begin
							nx.scl_high = 1'b1;
						end else begin
							nx.scl_high = 1'b0;
							if (nx.bit_cnt < 4'd8) begin
								if (reading) begin
									nx.shreg = {nx.shreg[6:0], item.sda_sample};
									if (nx.bit_cnt == 4'd7) begin
										res.read_valid = 1'b1;
										res.read_data  = nx.shreg;
										res.read_last  = nx.bytes_left == 9'd1;
									end
								end else begin
									nx.shreg = {nx.shreg[6:0], 1'b0};
								end
								nx.bit_cnt = nx.bit_cnt + 4'd1;
							end else begin
								if (!reading && item.sda_sample) begin
									nx.nack = 1'b1;
								end
								// advance to the next segment
								nx.bit_cnt = '0;
								nx.shreg   = '0;
								case (nx.phase)
									PH_ADDR_W: begin
										nx.phase = PH_REG;
										nx.shreg = nx.held_reg;
									end
									PH_REG: begin
										if (nx.held_op == OP_WRITE) begin
											nx.phase = PH_DATA;
											nx.shreg = nx.held_data;
										end else begin
											nx.phase = PH_STOP_MID;
										end
									end
									PH_DATA: begin
										nx.phase = PH_STOP_END;
									end
									PH_ADDR_R: begin
										nx.phase = (nx.bytes_left != 9'd0) ? PH_READ : PH_STOP_END;
									end
									default: begin
										nx.bytes_left = nx.bytes_left - 9'd1;
										nx.phase = (nx.bytes_left != 9'd0) ? PH_READ : PH_STOP_END;
									end
								endcase
							end
						end
					end
				end
				default: begin
				end
			endcase
			nx.tick_cnt = last_tick ? 10'd0 : tick_sum[9:0];
		end
	end

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// I2C register-access master: each accepted item is one bus tick.
// A tick is captured in the input register, then passes through the sequencer
// logic into the result register.
// Throughput: one tick per cycle while the result channel does not stall.
// Reset (arst_n low, asynchronous): sequencer idle, all counters clear,
// half_bit_q back to 10, both pipeline stages empty.
module i2c_master_register_access import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// tick input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [6:0] device_address,
	input  logic [7:0] register_address,
	input  logic [7:0] write_data,
	input  logic [8:0] read_count,
	input  logic       sda_sample,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_drive_low,
	output logic       sda_drive_low,
	output logic       busy_res,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic       read_last,
	output logic       done_res,
	output logic       ack_missing,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] half_bit_ticks
);

	tick_item_t item_s1;
	logic       valid_s1;
	tick_res_t  res_comb;
	tick_res_t  res_s2;
	logic       valid_s2;
	logic [9:0] half_bit_q;
	logic       out_free;
	logic       fire;
	logic       in_take;

	// The result register is free when empty or being drained this cycle.
	assign out_free = ~valid_s2 | ~out_stall;
	assign fire     = valid_s1 & out_free;
	// Hold the input side only when a tick is waiting behind a stalled result.
	assign in_stall = valid_s1 & ~out_free;
	assign in_take  = in_valid & ~in_stall;

	// The user must write configuration only between transactions; the block does not enforce it and takes it at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_bit_q <= half_bit_ticks;
		end
	end

	// Input register: capture the tick, drop it once the sequencer consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{operation:        operation,
			             device_address:   device_address,
			             register_address: register_address,
			             write_data:       write_data,
			             read_count:       read_count,
			             sda_sample:       sda_sample};
		end
	end

	// Sequencer: state advances exactly once per consumed tick.
	i2cm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.half_bit (half_bit_q),
		.res      (res_comb)
	);

	// Result register: load on fire, drop when the downstream takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid     = valid_s2;
	assign scl_drive_low = res_s2.scl_drive_low;
	assign sda_drive_low = res_s2.sda_drive_low;
	assign busy_res      = res_s2.busy;
	assign read_valid    = res_s2.read_valid;
	assign read_data     = res_s2.read_data;
	assign read_last     = res_s2.read_last;
	assign done_res      = res_s2.done;
	assign ack_missing   = res_s2.ack_missing;

endmodule
